@@ rtl/perm_enum_pkg.sv @@
// Shared constants and types for the permutation enumerator.
// Holds the stream field widths, the operation codes and the sequencer state type.
// No dependencies.
`default_nettype none

package perm_enum_pkg;

	// Default capacity of the element store.
	localparam int MAX_ELEMS_DEF = 8;

	// Field widths of the request and result items.
	localparam int OP_W         = 2;
	localparam int ELEM_W       = 16;
	localparam int POS_W        = 3;
	localparam int S_TDATA_W    = 16;
	localparam int M_TDATA_W    = 24;
	localparam int M_TDATA_PAD  = M_TDATA_W - ELEM_W - POS_W;
	localparam int M_TUSER_W    = 2;

	// Operation codes carried in the request tuser field.
	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_NEXT  = 2'd2
	} op_t;

	// Sequencer states, one-hot.
	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_UNDO  = 12'b0000_0000_0010,
		ST_ADV   = 12'b0000_0000_0100,
		ST_ADV2  = 12'b0000_0000_1000,
		ST_FILL  = 12'b0000_0001_0000,
		ST_SWA   = 12'b0000_0010_0000,
		ST_SWB   = 12'b0000_0100_0000,
		ST_SWW1  = 12'b0000_1000_0000,
		ST_SWW2  = 12'b0001_0000_0000,
		ST_EMRD  = 12'b0010_0000_0000,
		ST_EMOUT = 12'b0100_0000_0000,
		ST_MARK  = 12'b1000_0000_0000
	} state_t;

endpackage

`default_nettype wire

@@ rtl/permutation_enumerator.sv @@
// Permutation enumerator, one request in work at a time with s_tready low until it ends.
// A next request pops levels that have run out, undoing their swaps, until one can move on, and
// then emits every element; a load first undoes every swap in force. Output stalls hold a next request.
// Swaps set the pace: the element store has one read and one write port, so each swap runs through ST_SWA,
// ST_SWB, ST_SWW1 and ST_SWW2. arst_n clears all control state at once; the store has no reset and is read
// below the count. Depends on perm_enum_pkg.
`default_nettype none

module permutation_enumerator
	import perm_enum_pkg::*;
#(
	parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Request side.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] value
	input  wire logic [OP_W-1:0]       s_tuser,   // [1:0] operation
	// Result side.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,   // [15:0] element, [18:16] position, rest zero
	output logic                       m_tlast,   // last_of_run
	output logic [M_TUSER_W-1:0]       m_tuser    // [0] empty_permutation, [1] exhausted
);

	// Index width into the element store and width of counts that can reach MAX_ELEMS.
	localparam int IW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
	localparam int CW = $clog2(MAX_ELEMS + 1);

	// Sequencer and backtracking stack.
	state_t               state_q;
	state_t               ret_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        depth_q;
	logic [CW-1:0]        k_q;
	logic [CW-1:0]        idx_q [MAX_ELEMS];
	logic                 started_q;
	logic                 finished_q;
	logic [IW-1:0]        sw_a_q;
	logic [IW-1:0]        sw_b_q;
	logic [IW-1:0]        pos_q;
	logic                 mark_empty_q;
	logic                 mark_exh_q;

	// Element store and its data path.
	logic [ELEM_W-1:0]    mem [MAX_ELEMS];
	logic [ELEM_W-1:0]    val_q;
	logic [ELEM_W-1:0]    tmp_q;
	logic [ELEM_W-1:0]    rd_data_q;

	// Output register.
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 m_tlast_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	logic                 rd_en;
	logic [IW-1:0]        rd_addr;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic [ELEM_W-1:0]    wr_data;
	logic                 out_free;
	logic                 emit_last;
	logic [CW-1:0]        k_dec;
	logic [CW-1:0]        depth_dec;
	logic [CW-1:0]        idx_at_kdec;
	logic [CW-1:0]        idx_at_ddec;
	logic [CW-1:0]        idx_inc;
	logic [IW+POS_W-1:0]  pos_ext;
	op_t                  op;

	assign s_tready  = (state_q == ST_IDLE);
	assign op        = op_t'(s_tuser);
	assign out_free  = !m_tvalid_q || m_tready;
	assign k_dec     = k_q - CW'(1);
	assign depth_dec = depth_q - CW'(1);
	assign idx_at_kdec = idx_q[k_dec[IW-1:0]];
	assign idx_at_ddec = idx_q[depth_dec[IW-1:0]];
	assign idx_inc   = idx_q[k_q[IW-1:0]] + CW'(1);
	assign emit_last = (CW'(pos_q) + CW'(1)) == count_q;
	assign pos_ext   = {{POS_W{1'b0}}, pos_q};

	// The store has one read port and one write port. A swap reads the first entry, then the
	// second while the first is parked in tmp_q, then writes both back crosswise.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = sw_a_q;
		wr_en   = 1'b0;
		wr_addr = sw_a_q;
		wr_data = rd_data_q;
		case (state_q)
			ST_SWA: begin
				rd_en   = 1'b1;
				rd_addr = sw_a_q;
			end
			ST_SWB: begin
				rd_en   = 1'b1;
				rd_addr = sw_b_q;
			end
			ST_EMRD: begin
				rd_en   = 1'b1;
				rd_addr = pos_q;
			end
			ST_SWW1: begin
				wr_en   = 1'b1;
				wr_addr = sw_a_q;
				wr_data = rd_data_q;
			end
			ST_SWW2: begin
				wr_en   = 1'b1;
				wr_addr = sw_b_q;
				wr_data = tmp_q;
			end
			ST_UNDO: begin
				// Once every swap is undone the new value goes in behind the others.
				wr_en   = (depth_q == '0);
				wr_addr = count_q[IW-1:0];
				wr_data = val_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (state_q == ST_SWB) begin
			tmp_q <= rd_data_q;
		end
		if (s_tvalid && s_tready && op == OP_LOAD) begin
			val_q <= s_tdata;
		end
		if (out_free && state_q == ST_EMOUT) begin
			m_tdata_q <= {{M_TDATA_PAD{1'b0}}, pos_ext[POS_W-1:0], rd_data_q};
			m_tlast_q <= emit_last;
			m_tuser_q <= '0;
		end else if (out_free && state_q == ST_MARK) begin
			m_tdata_q <= '0;
			m_tlast_q <= 1'b1;
			m_tuser_q <= {mark_exh_q, mark_empty_q};
		end
	end

	// Sequencer. The recursion of the swap-and-undo search is held as one loop index per level;
	// advancing pops levels from the deepest, undoing each swap, until one level can move on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ret_q        <= ST_IDLE;
			count_q      <= '0;
			depth_q      <= '0;
			k_q          <= '0;
			started_q    <= 1'b0;
			finished_q   <= 1'b0;
			sw_a_q       <= '0;
			sw_b_q       <= '0;
			pos_q        <= '0;
			mark_empty_q <= 1'b0;
			mark_exh_q   <= 1'b0;
			m_tvalid_q   <= 1'b0;
			for (int j = 0; j < MAX_ELEMS; j++) begin
				idx_q[j] <= '0;
			end
		end else begin
			if ((state_q == ST_EMOUT || state_q == ST_MARK) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (op)
							OP_LOAD: begin
								// A load into a full store is dropped without a restart.
								if (count_q < CW'(MAX_ELEMS)) begin
									state_q <= ST_UNDO;
								end
							end
							OP_CLEAR: begin
								count_q    <= '0;
								depth_q    <= '0;
								started_q  <= 1'b0;
								finished_q <= 1'b0;
								for (int j = 0; j < MAX_ELEMS; j++) begin
									idx_q[j] <= '0;
								end
							end
							OP_NEXT: begin
								if (finished_q) begin
									mark_empty_q <= 1'b0;
									mark_exh_q   <= 1'b1;
									state_q      <= ST_MARK;
								end else if (count_q == '0) begin
									// The empty set has exactly one, empty, permutation.
									if (!started_q) begin
										started_q    <= 1'b1;
										mark_empty_q <= 1'b1;
										mark_exh_q   <= 1'b0;
									end else begin
										finished_q   <= 1'b1;
										mark_empty_q <= 1'b0;
										mark_exh_q   <= 1'b1;
									end
									state_q <= ST_MARK;
								end else if (!started_q) begin
									started_q <= 1'b1;
									for (int j = 0; j < MAX_ELEMS; j++) begin
										idx_q[j] <= CW'(j);
									end
									depth_q <= count_q;
									pos_q   <= '0;
									state_q <= ST_EMRD;
								end else begin
									k_q     <= count_q;
									state_q <= ST_ADV;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_UNDO: begin
					if (depth_q == '0) begin
						count_q    <= count_q + CW'(1);
						started_q  <= 1'b0;
						finished_q <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						depth_q <= depth_dec;
						sw_a_q  <= depth_dec[IW-1:0];
						sw_b_q  <= idx_at_ddec[IW-1:0];
						ret_q   <= ST_UNDO;
						state_q <= ST_SWA;
					end
				end
				ST_ADV: begin
					if (k_q == '0) begin
						// Every level has run out: the enumeration is complete.
						depth_q      <= '0;
						finished_q   <= 1'b1;
						mark_empty_q <= 1'b0;
						mark_exh_q   <= 1'b1;
						state_q      <= ST_MARK;
					end else begin
						k_q     <= k_dec;
						sw_a_q  <= k_dec[IW-1:0];
						sw_b_q  <= idx_at_kdec[IW-1:0];
						ret_q   <= ST_ADV2;
						state_q <= ST_SWA;
					end
				end
				ST_ADV2: begin
					idx_q[k_q[IW-1:0]] <= idx_inc;
					if (idx_inc < count_q) begin
						sw_a_q  <= k_q[IW-1:0];
						sw_b_q  <= idx_inc[IW-1:0];
						ret_q   <= ST_FILL;
						state_q <= ST_SWA;
					end else begin
						state_q <= ST_ADV;
					end
				end
				ST_FILL: begin
					for (int j = 0; j < MAX_ELEMS; j++) begin
						if (CW'(j) > k_q) begin
							idx_q[j] <= CW'(j);
						end
					end
					depth_q <= count_q;
					pos_q   <= '0;
					state_q <= ST_EMRD;
				end
				ST_SWA: begin
					state_q <= ST_SWB;
				end
				ST_SWB: begin
					state_q <= ST_SWW1;
				end
				ST_SWW1: begin
					state_q <= ST_SWW2;
				end
				ST_SWW2: begin
					state_q <= ret_q;
				end
				ST_EMRD: begin
					state_q <= ST_EMOUT;
				end
				ST_EMOUT: begin
					if (out_free) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q   <= pos_q + IW'(1);
							state_q <= ST_EMRD;
						end
					end
				end
				ST_MARK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	// No more swaps can be in force than there are elements loaded.
	assert property (@(posedge clk) disable iff (!arst_n) depth_q <= count_q)
		else $error("swap depth exceeds element count");

	// The fill count never passes the capacity of the store.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_ELEMS))
		else $error("element count beyond capacity");

	// Once exhausted, the stack has been fully unwound.
	assert property (@(posedge clk) disable iff (!arst_n) finished_q |-> depth_q == '0)
		else $error("exhausted with swaps still in force");

	// A marker result always closes its run on its own.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != '0) |-> (m_tlast && m_tdata == '0))
		else $error("marker result not a lone final item");

endmodule

`default_nettype wire
